@@ design/priority_wait_list_unit_macros.svh @@
// ---------------------------------------------------------------------------
// priority_wait_list_unit_macros.svh
// Assertion shorthands for the priority wait list.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_WAIT_LIST_UNIT_MACROS_SVH
`define PRIORITY_WAIT_LIST_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pwl_pkg.sv @@
// ---------------------------------------------------------------------------
// pwl_pkg
// Shared codes and controller/datapath interface types of the wait list.
// ---------------------------------------------------------------------------
`default_nettype none

package pwl_pkg;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_WAKE_ONE = 2'd2,
        OP_WAKE_ALL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } resp_code_t;

    // source of the woken identifier in a result item
    typedef enum logic [1:0] {
        WSEL_NONE  = 2'd0,
        WSEL_BEST  = 2'd1,
        WSEL_ENTRY = 2'd2
    } wsel_t;

    typedef struct packed {
        logic       cap;        // capture the accepted item
        logic       idx_clr;    // index to slot 0
        logic       idx_inc;    // advance index
        logic       idx_best;   // index to best slot
        logic       rd_cur;     // read slot idx
        logic       rd_nxt;     // read slot idx+1
        logic       wr_tail;    // append captured entry, bump occupancy
        logic       wr_shift;   // write read data into slot idx
        logic       occ_dec;
        logic       occ_clr;
        logic       best_clr;
        logic       best_upd;   // compare read data against best so far
        logic       emit;       // load the output register
        wsel_t      emit_sel;
        resp_code_t emit_status;
        logic       emit_last;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic idx_end;   // idx == occupancy
        logic idx_last;  // idx + 1 == occupancy
        logic match;     // read id equals captured id
        logic out_free;  // output register can take an item
    } stat_t;

endpackage

`default_nettype wire

@@ design/pwl_ctrl.sv @@
// ---------------------------------------------------------------------------
// pwl_ctrl
// Sequencer for add, remove, wake-one and wake-all operations.
// ---------------------------------------------------------------------------
`default_nettype none

module pwl_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire pwl_pkg::stat_t stat,
    output pwl_pkg::cmd_t      cmd
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DISPATCH = 11'b000_0000_0010,
        S_RM_CHK   = 11'b000_0000_0100,
        S_RM_CMP   = 11'b000_0000_1000,
        S_W1_CHK   = 11'b000_0001_0000,
        S_W1_CMP   = 11'b000_0010_0000,
        S_SH_CHK   = 11'b000_0100_0000,
        S_SH_WR    = 11'b000_1000_0000,
        S_WA_RD    = 11'b001_0000_0000,
        S_WA_OUT   = 11'b010_0000_0000,
        S_RESULT   = 11'b100_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    pwl_pkg::resp_code_t  pend_status_reg, pend_status_next;
    pwl_pkg::wsel_t       pend_sel_reg, pend_sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            pend_status_reg <= pwl_pkg::ST_OK;
            pend_sel_reg    <= pwl_pkg::WSEL_NONE;
        end else begin
            state_reg       <= state_next;
            pend_status_reg <= pend_status_next;
            pend_sel_reg    <= pend_sel_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next       = state_reg;
        pend_status_next = pend_status_reg;
        pend_sel_next    = pend_sel_reg;
        cmd              = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.cap    = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                pend_status_next = pwl_pkg::ST_OK;
                pend_sel_next    = pwl_pkg::WSEL_NONE;
                case (stat.op)
                    pwl_pkg::OP_ADD: begin
                        if (stat.full) begin
                            pend_status_next = pwl_pkg::ST_FULL;
                        end else begin
                            cmd.wr_tail = 1'b1;
                        end
                        state_next = S_RESULT;
                    end
                    pwl_pkg::OP_REMOVE: begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_RM_CHK;
                    end
                    pwl_pkg::OP_WAKE_ONE: begin
                        if (stat.empty) begin
                            pend_status_next = pwl_pkg::ST_EMPTY;
                            state_next       = S_RESULT;
                        end else begin
                            cmd.idx_clr   = 1'b1;
                            cmd.best_clr  = 1'b1;
                            pend_sel_next = pwl_pkg::WSEL_BEST;
                            state_next    = S_W1_CHK;
                        end
                    end
                    pwl_pkg::OP_WAKE_ALL: begin
                        if (stat.empty) begin
                            pend_status_next = pwl_pkg::ST_EMPTY;
                            state_next       = S_RESULT;
                        end else begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_WA_RD;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RM_CHK: begin
                if (stat.idx_end) begin
                    pend_status_next = pwl_pkg::ST_NOT_FOUND;
                    state_next       = S_RESULT;
                end else begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                if (stat.match) begin
                    state_next = S_SH_CHK;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RM_CHK;
                end
            end
            S_W1_CHK: begin
                if (stat.idx_end) begin
                    cmd.idx_best = 1'b1;
                    state_next   = S_SH_CHK;
                end else begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_W1_CMP;
                end
            end
            S_W1_CMP: begin
                cmd.best_upd = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_W1_CHK;
            end
            S_SH_CHK: begin
                if (stat.idx_last) begin
                    cmd.occ_dec = 1'b1;
                    state_next  = S_RESULT;
                end else begin
                    cmd.rd_nxt = 1'b1;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_SH_CHK;
            end
            S_WA_RD: begin
                cmd.rd_cur = 1'b1;
                state_next = S_WA_OUT;
            end
            S_WA_OUT: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = pwl_pkg::WSEL_ENTRY;
                    cmd.emit_status = pwl_pkg::ST_OK;
                    cmd.emit_last   = stat.idx_last;
                    cmd.idx_inc     = 1'b1;
                    if (stat.idx_last) begin
                        cmd.occ_clr = 1'b1;
                        state_next  = S_IDLE;
                    end else begin
                        state_next  = S_WA_RD;
                    end
                end
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = pend_sel_reg;
                    cmd.emit_status = pend_status_reg;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/pwl_datapath.sv @@
// ---------------------------------------------------------------------------
// pwl_datapath
// Entry memory, scan index, best-entry tracker and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pwl_datapath #(
    parameter  int LIST_DEPTH = 16,
    parameter  int ID_BITS    = 8,
    parameter  int PRIO_BITS  = 8,
    localparam int S_DW       = ((ID_BITS + PRIO_BITS + 7) / 8) * 8,
    localparam int M_DW       = ((ID_BITS + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [S_DW-1:0]  s_tdata,
    input  wire logic [1:0]       s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [M_DW-1:0]       m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast,
    input  wire pwl_pkg::cmd_t    cmd,
    output pwl_pkg::stat_t        stat
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int IW = $clog2(LIST_DEPTH + 1);
    localparam int EW = ID_BITS + PRIO_BITS;

    logic [EW-1:0]        mem [LIST_DEPTH];
    logic [EW-1:0]        rdata_reg;

    pwl_pkg::op_t         op_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [PRIO_BITS-1:0] prio_reg;

    logic [IW-1:0]        occ_reg;
    logic [IW-1:0]        idx_reg;
    logic [IW-1:0]        idx_plus1;

    logic                 best_vld_reg;
    logic [IW-1:0]        best_idx_reg;
    logic [PRIO_BITS-1:0] best_prio_reg;
    logic [ID_BITS-1:0]   best_id_reg;

    logic                 out_vld_reg;
    logic [ID_BITS-1:0]   out_id_reg;
    pwl_pkg::resp_code_t  out_status_reg;
    logic                 out_last_reg;

    logic [ID_BITS-1:0]   rd_id;
    logic [PRIO_BITS-1:0] rd_prio;

    assign rd_id     = rdata_reg[ID_BITS-1:0];
    assign rd_prio   = rdata_reg[EW-1:ID_BITS];
    assign idx_plus1 = idx_reg + IW'(1);

    // captured item
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            op_reg   <= pwl_pkg::op_t'(s_tuser);
            id_reg   <= s_tdata[ID_BITS-1:0];
            prio_reg <= s_tdata[ID_BITS +: PRIO_BITS];
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.wr_tail) begin
            mem[occ_reg[AW-1:0]] <= {prio_reg, id_reg};
        end else if (cmd.wr_shift) begin
            mem[idx_reg[AW-1:0]] <= rdata_reg;
        end
        if (cmd.rd_cur) begin
            rdata_reg <= mem[idx_reg[AW-1:0]];
        end else if (cmd.rd_nxt) begin
            rdata_reg <= mem[idx_plus1[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (cmd.wr_tail) begin
            occ_reg <= occ_reg + IW'(1);
        end else if (cmd.occ_dec) begin
            occ_reg <= occ_reg - IW'(1);
        end else if (cmd.occ_clr) begin
            occ_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_best) begin
            idx_reg <= best_idx_reg;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_plus1;
        end
    end

    // strict compare keeps the earliest entry among equal priorities
    always_ff @(posedge aclk) begin
        if (cmd.best_clr) begin
            best_vld_reg <= 1'b0;
        end else if (cmd.best_upd && (!best_vld_reg || rd_prio > best_prio_reg)) begin
            best_vld_reg  <= 1'b1;
            best_idx_reg  <= idx_reg;
            best_prio_reg <= rd_prio;
            best_id_reg   <= rd_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_status_reg <= cmd.emit_status;
            out_last_reg   <= cmd.emit_last;
            case (cmd.emit_sel)
                pwl_pkg::WSEL_BEST:  out_id_reg <= best_id_reg;
                pwl_pkg::WSEL_ENTRY: out_id_reg <= rd_id;
                default:             out_id_reg <= '0;
            endcase
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_DW'(out_id_reg);
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    assign stat.op       = op_reg;
    assign stat.full     = (occ_reg == IW'(LIST_DEPTH));
    assign stat.empty    = (occ_reg == '0);
    assign stat.idx_end  = (idx_reg == occ_reg);
    assign stat.idx_last = (idx_plus1 == occ_reg);
    assign stat.match    = (rd_id == id_reg);
    assign stat.out_free = !out_vld_reg || m_tready;

endmodule

`default_nettype wire

@@ design/priority_wait_list_unit.sv @@
// Steps per item: add dispatches, then emits its result; remove compares entries in turn
//   until a match, then shifts each later entry down a slot; wake-one compares every entry,
//   then shifts out the best; an empty wake emits at once; wake-all reads and emits each entry.
// Flow: one item at a time, next accept the cycle after its last result is loaded; a stalled
//   output delays each result until the output register is free.
// Reset: synchronous active-low aresetn empties the list and clears the output register.
// ---------------------------------------------------------------------------
// priority_wait_list_unit
// Wait list of thread ids with priorities: add, remove by id, wake highest
// priority (earliest among equals), wake all in arrival order.
// ---------------------------------------------------------------------------
`default_nettype none

`include "priority_wait_list_unit_macros.svh"

module priority_wait_list_unit #(
    parameter  int LIST_DEPTH = 16,
    parameter  int ID_BITS    = 8,
    parameter  int PRIO_BITS  = 8,
    localparam int S_DW       = ((ID_BITS + PRIO_BITS + 7) / 8) * 8,
    localparam int M_DW       = ((ID_BITS + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // input items
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [S_DW-1:0]  s_tdata,   // thread_id, priority_req, zero pad
    input  wire logic [1:0]       s_tuser,   // op
    // result items
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [M_DW-1:0]       m_tdata,   // woken_id, zero pad
    output logic [1:0]            m_tuser,   // status
    output logic                  m_tlast    // final result of an item
);

    pwl_pkg::cmd_t  cmd;
    pwl_pkg::stat_t stat;

    // Sequence each item: dispatch on op, scan/shift over the memory, emit results.
    pwl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the entries, the scan index and the best candidate; drive the result port.
    pwl_datapath #(
        .LIST_DEPTH (LIST_DEPTH),
        .ID_BITS    (ID_BITS),
        .PRIO_BITS  (PRIO_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Never append into a full list.
    `PWL_ASSERT_SAME(a_no_add_when_full, aclk, aresetn, cmd.wr_tail, !stat.full, "add into full list")
    // Never overwrite a result that is still waiting.
    `PWL_ASSERT_SAME(a_emit_free, aclk, aresetn, cmd.emit, stat.out_free, "result overwritten")
    // Never drop an entry from an empty list.
    `PWL_ASSERT_SAME(a_dec_nonempty, aclk, aresetn, cmd.occ_dec, !stat.empty, "occupancy underflow")
    // One item at a time: after an accept the input side closes.
    `PWL_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item taken")

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the priority wait list. A local model of the list
// predicts every result item of add, remove, wake-one and wake-all, and a
// monitor compares each accepted result against the oldest prediction.
// The input and result streams are throttled in several idle patterns, and
// one phase backs up the output to stall the input.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 260;

    // one expected result item
    typedef struct {
        logic [7:0]          woken_id;
        pwl_pkg::resp_code_t status;
        logic                last;
    } wake_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // thread_id, priority_req
    logic [1:0]  s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // woken_id
    logic [1:0]  m_tuser;   // status
    logic        m_tlast;

    // local copy of the wait list, in arrival order
    logic [7:0] list_ids   [DEPTH];
    logic [7:0] list_prios [DEPTH];
    int         list_count;

    wake_result_t pending_results[$];

    int  mismatches;
    int  cycle_count;
    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  rx_hold;

    priority_wait_list_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Close the gap left by slot pos and shrink the list.
    function automatic void close_gap(int pos);
        for (int i = pos; i + 1 < list_count; i++) begin
            list_ids[i]   = list_ids[i + 1];
            list_prios[i] = list_prios[i + 1];
        end
        list_count--;
    endfunction

    function automatic void push_result(logic [7:0] id, pwl_pkg::resp_code_t st, logic last);
        wake_result_t r;
        r.woken_id = id;
        r.status   = st;
        r.last     = last;
        pending_results.push_back(r);
    endfunction

    // Apply one accepted item to the local list and queue its results.
    function automatic void predict_wait_list_op(pwl_pkg::op_t op, logic [7:0] id,
                                                 logic [7:0] prio);
        int pos;
        int best;
        logic [7:0] woken;
        pos = -1;
        case (op)
            pwl_pkg::OP_ADD: begin
                if (list_count >= DEPTH) begin
                    push_result(8'd0, pwl_pkg::ST_FULL, 1'b1);
                end else begin
                    list_ids[list_count]   = id;
                    list_prios[list_count] = prio;
                    list_count++;
                    push_result(8'd0, pwl_pkg::ST_OK, 1'b1);
                end
            end
            pwl_pkg::OP_REMOVE: begin
                // first match only
                for (int i = 0; i < list_count && pos < 0; i++)
                    if (list_ids[i] == id)
                        pos = i;
                if (pos >= 0) begin
                    close_gap(pos);
                    push_result(8'd0, pwl_pkg::ST_OK, 1'b1);
                end else begin
                    push_result(8'd0, pwl_pkg::ST_NOT_FOUND, 1'b1);
                end
            end
            pwl_pkg::OP_WAKE_ONE: begin
                if (list_count == 0) begin
                    push_result(8'd0, pwl_pkg::ST_EMPTY, 1'b1);
                end else begin
                    // strict compare keeps the earliest among equals
                    best = 0;
                    for (int i = 1; i < list_count; i++)
                        if (list_prios[i] > list_prios[best])
                            best = i;
                    woken = list_ids[best];
                    close_gap(best);
                    push_result(woken, pwl_pkg::ST_OK, 1'b1);
                end
            end
            default: begin
                if (list_count == 0) begin
                    push_result(8'd0, pwl_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < list_count; i++)
                        push_result(list_ids[i], pwl_pkg::ST_OK, i + 1 == list_count);
                    list_count = 0;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side: entered at a falling edge, leaves at a falling edge
    // with tvalid low.
    // ------------------------------------------------------------------
    task automatic send_item(pwl_pkg::op_t op, logic [7:0] id, logic [7:0] prio);
        // idle a random number of cycles first
        while ($urandom_range(0, 99) < tx_idle_pct)
            @(negedge aclk);
        s_tuser  = op;
        s_tdata  = {prio, id};
        s_tvalid = 1'b1;
        // hold the item until accepted
        do @(posedge aclk); while (!s_tready);
        predict_wait_list_op(op, id, prio);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Wait until every predicted result has arrived.
    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off when rx_hold is set.
    // ------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Compare each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        wake_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t result expected none actual woken_id %0h status %0d last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata !== exp_r.woken_id) begin
                    mismatches++;
                    $display("%0t woken_id expected %0h actual %0h",
                             $time, exp_r.woken_id, m_tdata);
                end
                if (m_tuser !== exp_r.status) begin
                    mismatches++;
                    $display("%0t status expected %0d actual %0d",
                             $time, exp_r.status, m_tuser);
                end
                if (m_tlast !== exp_r.last) begin
                    mismatches++;
                    $display("%0t last expected %0b actual %0b",
                             $time, exp_r.last, m_tlast);
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Wake-one, wake-all and remove on a freshly reset, empty list.
    task automatic test_empty_list();
        send_item(pwl_pkg::OP_WAKE_ONE, 8'h00, 8'h01);
        send_item(pwl_pkg::OP_WAKE_ALL, 8'hFF, 8'hFF);
        send_item(pwl_pkg::OP_REMOVE,   8'h00, 8'h01);
    endtask

    // Fill every slot, with extreme ids and priorities, a duplicate id,
    // a zero priority and a tie on the top priority; then add past full.
    task automatic test_fill_to_full();
        logic [7:0] id;
        logic [7:0] prio;
        for (int i = 0; i < DEPTH; i++) begin
            case (i)
                0:       begin id = 8'h00; prio = 8'h00; end
                1:       begin id = 8'hFF; prio = 8'hFF; end
                2:       begin id = 8'h5A; prio = 8'h01; end
                3:       begin id = 8'hA5; prio = 8'hFF; end
                6:       begin id = 8'h5A; prio = 8'h80; end
                default: begin id = 8'(8'h10 + i * 17); prio = 8'(i * 37 + 3); end
            endcase
            send_item(pwl_pkg::OP_ADD, id, prio);
        end
        send_item(pwl_pkg::OP_ADD, 8'h77, 8'h7F);
    endtask

    // Wake the earlier of two top entries, drop a duplicate id,
    // miss an absent id, then flush the rest.
    task automatic test_wake_and_remove();
        send_item(pwl_pkg::OP_WAKE_ONE, 8'h00, 8'h01);
        send_item(pwl_pkg::OP_REMOVE,   8'h5A, 8'h01);
        send_item(pwl_pkg::OP_REMOVE,   8'hEE, 8'h01);
        send_item(pwl_pkg::OP_WAKE_ALL, 8'h00, 8'h01);
    endtask

    // All entries tie at priority zero: the first one is woken.
    task automatic test_priority_ties();
        send_item(pwl_pkg::OP_ADD,      8'h21, 8'h00);
        send_item(pwl_pkg::OP_ADD,      8'h12, 8'h00);
        send_item(pwl_pkg::OP_WAKE_ONE, 8'h00, 8'h01);
        send_item(pwl_pkg::OP_WAKE_ALL, 8'h00, 8'h01);
    endtask

    // Pick one random item, leaning toward ids that are on the list so
    // removes hit, and toward a small id pool so duplicates occur.
    task automatic send_random_item();
        int           pick;
        pwl_pkg::op_t op;
        logic [7:0]   id;
        logic [7:0]   prio;
        pick = $urandom_range(0, 99);
        if (pick < 48)      op = pwl_pkg::OP_ADD;
        else if (pick < 68) op = pwl_pkg::OP_REMOVE;
        else if (pick < 92) op = pwl_pkg::OP_WAKE_ONE;
        else                op = pwl_pkg::OP_WAKE_ALL;
        if ($urandom_range(0, 1) == 0)
            id = 8'($urandom_range(0, 7));
        else
            id = 8'($urandom_range(0, 255));
        if (op == pwl_pkg::OP_REMOVE && list_count > 0 && $urandom_range(0, 99) < 80)
            id = list_ids[$urandom_range(0, list_count - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 5)       prio = 8'h00;
        else if (pick < 15) prio = 8'h01;
        else if (pick < 25) prio = 8'hFF;
        else if (pick < 40) prio = 8'($urandom_range(1, 4));
        else                prio = 8'($urandom_range(1, 255));
        send_item(op, id, prio);
    endtask

    task automatic test_random_traffic(int count, int tx_pct, int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) send_random_item();
    endtask

    // Hold off the receiver for a long stretch while the sender keeps
    // offering items, so the block backs up and stalls its input.
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(posedge aclk);
                rx_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 10; i++)
            send_item(pwl_pkg::OP_ADD, 8'(8'hC0 + i), 8'(i * 20 + 5));
        send_item(pwl_pkg::OP_WAKE_ALL, 8'h00, 8'h01);
        send_item(pwl_pkg::OP_WAKE_ONE, 8'h00, 8'h01);
        send_item(pwl_pkg::OP_ADD,      8'h3C, 8'h90);
        send_item(pwl_pkg::OP_WAKE_ALL, 8'h00, 8'h01);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = pwl_pkg::OP_ADD;
        mismatches   = 0;
        list_count   = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_list();
        test_fill_to_full();
        test_wake_and_remove();
        test_priority_ties();
        test_random_traffic(RANDOM_ITEMS / 4, 0, 0);
        test_random_traffic(RANDOM_ITEMS / 4, 66, 0);
        test_random_traffic(RANDOM_ITEMS / 4, 0, 66);
        test_random_traffic(RANDOM_ITEMS / 4, 6, 6);
        test_output_backpressure();

        wait_drained();
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
